### rtl/imsf_pkg.sv
// Package for the incremental minimum spanning forest block.
// Holds the field widths, default sizes and the transfer payload structs.
// No dependencies.
package imsf_pkg;

    localparam int NODE_W          = 8;
    localparam int WEIGHT_W        = 16;
    localparam int TOTAL_W         = 24;
    localparam int COUNT_W         = 8;
    localparam int MAX_NODES_DEF   = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    typedef struct packed {
        logic                first_of_case;
        logic [NODE_W-1:0]   end_a;
        logic [NODE_W-1:0]   end_b;
        logic [WEIGHT_W-1:0] weight;
    } imsf_in_t;

    typedef struct packed {
        logic               connected;
        logic [TOTAL_W-1:0] total_weight;
        logic [COUNT_W-1:0] forest_size;
    } imsf_out_t;

endpackage

### rtl/incremental_min_spanning_forest_top.sv
// Top level of the incremental minimum spanning forest block.
// Depends on imsf_pkg and imsf_ram.
//
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we                    cfg_data = node_count
// edge      in         edge_valid / edge_stall   edge_data   (imsf_in_t)
// result    out        result_valid/result_stall result_data (imsf_out_t)
//
// Per edge transfer: the edge is accepted, all MAX_NODES entries of the parent table
// are reinitialized, each stored edge is fetched (the one the new edge precedes is
// fetched twice), and per candidate two root finds and one union step run, then the
// result is posted.
// Reset empties the forest and sets node_count to 1. A result holds in its output
// register while result_stall is high, and the block waits to post the next one.
module incremental_min_spanning_forest_top #(
    parameter int MAX_NODES   = imsf_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = imsf_pkg::WEIGHT_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [imsf_pkg::NODE_W-1:0] cfg_data,
    input  logic                     edge_valid,
    output logic                     edge_stall,
    input  imsf_pkg::imsf_in_t       edge_data,
    output logic                     result_valid,
    input  logic                     result_stall,
    output imsf_pkg::imsf_out_t      result_data
);

    import imsf_pkg::*;

    localparam int IDX_W    = $clog2(MAX_NODES);
    localparam int EDGE_W   = WEIGHT_BITS + 2 * NODE_W;
    localparam int EADDR_W  = COUNT_W + 1;
    localparam int SUM_W    = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;
    localparam int NODE_CAP = MAX_NODES - 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIND_RD,
        S_FIND_P,
        S_FIND_G,
        S_UNION,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [NODE_W-1:0]      node_count_reg;
    logic [NODE_W-1:0]      n_eff_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   bank_reg;
    logic [IDX_W-1:0]       clr_reg;
    logic [COUNT_W-1:0]     rd_idx_reg;
    logic [COUNT_W-1:0]     kept_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   new_pend_reg;
    logic [WEIGHT_BITS-1:0] new_w_reg;
    logic [NODE_W-1:0]      new_a_reg;
    logic [NODE_W-1:0]      new_b_reg;
    logic [WEIGHT_BITS-1:0] cand_w_reg;
    logic [NODE_W-1:0]      cand_a_reg;
    logic [NODE_W-1:0]      cand_b_reg;
    logic [IDX_W-1:0]       fx_reg;
    logic                   which_reg;
    logic [IDX_W-1:0]       ra_reg;
    logic                   result_valid_reg;
    imsf_out_t              result_data_reg;

    logic [NODE_W-1:0]      n_in;
    logic [NODE_W-1:0]      n_now;
    logic                   in_ok;

    logic                   ewe;
    logic [EADDR_W-1:0]     ewaddr;
    logic [EDGE_W-1:0]      ewdata;
    logic [EADDR_W-1:0]     eraddr;
    logic [EDGE_W-1:0]      erdata;
    logic [WEIGHT_BITS-1:0] e_w;
    logic [NODE_W-1:0]      e_a;
    logic [NODE_W-1:0]      e_b;
    logic                   e_ok;
    logic                   new_less;

    logic                   pwe;
    logic [IDX_W-1:0]       pwaddr;
    logic [IDX_W-1:0]       pwdata;
    logic [IDX_W-1:0]       praddr;
    logic [IDX_W-1:0]       prdata;

    logic [SUM_W-1:0]       sum;
    logic [TOTAL_W-1:0]     total_sat;

    // Node count in effect, clamped to what the parent table can index
    assign n_in = (32'(node_count_reg) > NODE_CAP) ? NODE_W'(NODE_CAP) : node_count_reg;
    assign n_now = n_eff_reg;

    assign in_ok = (edge_data.end_a != '0) && (edge_data.end_a <= n_in)
                && (edge_data.end_b != '0) && (edge_data.end_b <= n_in)
                && (edge_data.end_a != edge_data.end_b);

    assign e_w = erdata[EDGE_W-1:2*NODE_W];
    assign e_a = erdata[2*NODE_W-1:NODE_W];
    assign e_b = erdata[NODE_W-1:0];

    assign e_ok = (e_a != '0) && (e_a <= n_now) && (e_b != '0) && (e_b <= n_now);

    // Sort order is (weight, end_a, end_b); the new edge goes in front of the
    // first stored edge that it strictly precedes
    assign new_less = (new_w_reg < e_w)
                   || ((new_w_reg == e_w) && ((new_a_reg < e_a)
                   || ((new_a_reg == e_a) && (new_b_reg < e_b))));

    assign sum       = SUM_W'(total_reg) + SUM_W'(cand_w_reg);
    assign total_sat = (sum > SUM_W'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

    // Edge store: read the current bank, write survivors to the other bank
    always_comb
    begin
        eraddr = {bank_reg, rd_idx_reg};
        ewe    = (state_reg == S_UNION) && (ra_reg != fx_reg);
        ewaddr = {~bank_reg, kept_reg};
        ewdata = {cand_w_reg, cand_a_reg, cand_b_reg};
    end

    // Parent table port control for the clear sweep, the find unit and union
    always_comb
    begin
        pwe    = 1'b0;
        pwaddr = fx_reg;
        pwdata = prdata;
        praddr = fx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                pwe    = 1'b1;
                pwaddr = clr_reg;
                pwdata = clr_reg;
            end
            S_FIND_P:
            begin
                praddr = prdata;
            end
            S_FIND_G:
            begin
                pwe    = 1'b1;
                pwaddr = fx_reg;
                pwdata = prdata;
                praddr = prdata;
            end
            S_UNION:
            begin
                pwe    = (ra_reg != fx_reg);
                pwaddr = ra_reg;
                pwdata = fx_reg;
            end
            default:
            begin
                pwe = 1'b0;
            end
        endcase
    end

    imsf_ram #(
        .ADDR_W (EADDR_W),
        .DATA_W (EDGE_W)
    ) u_edge_ram (
        .clk   (clk),
        .we    (ewe),
        .waddr (ewaddr),
        .wdata (ewdata),
        .raddr (eraddr),
        .rdata (erdata)
    );

    imsf_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (IDX_W)
    ) u_parent_ram (
        .clk   (clk),
        .we    (pwe),
        .waddr (pwaddr),
        .wdata (pwdata),
        .raddr (praddr),
        .rdata (prdata)
    );

    assign edge_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            node_count_reg   <= NODE_W'(1);
            count_reg        <= '0;
            bank_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            new_pend_reg     <= 1'b0;
            which_reg        <= 1'b0;
            clr_reg          <= '0;
            rd_idx_reg       <= '0;
            kept_reg         <= '0;
            total_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
            // Post a new result, or drop the old one once its transfer completes
            if ((state_reg == S_DONE) && (!result_valid_reg || !result_stall))
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (edge_valid)
                    begin
                        n_eff_reg    <= n_in;
                        new_pend_reg <= in_ok;
                        new_w_reg    <= WEIGHT_BITS'(edge_data.weight);
                        new_a_reg    <= edge_data.end_a;
                        new_b_reg    <= edge_data.end_b;
                        if (edge_data.first_of_case)
                        begin
                            count_reg <= '0;
                        end
                        clr_reg    <= '0;
                        rd_idx_reg <= '0;
                        kept_reg   <= '0;
                        total_reg  <= '0;
                        state_reg  <= S_CLEAR;
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IDX_W'(NODE_CAP))
                    begin
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    if (rd_idx_reg < count_reg)
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                    else if (new_pend_reg)
                    begin
                        new_pend_reg <= 1'b0;
                        cand_w_reg   <= new_w_reg;
                        cand_a_reg   <= new_a_reg;
                        cand_b_reg   <= new_b_reg;
                        fx_reg       <= IDX_W'(new_a_reg);
                        which_reg    <= 1'b0;
                        state_reg    <= S_FIND_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (!e_ok)
                    begin
                        // Stored edge names a node beyond the current count
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        state_reg  <= S_SCAN_RD;
                    end
                    else if (new_pend_reg && new_less)
                    begin
                        // Stored edge is fetched again after the new one
                        new_pend_reg <= 1'b0;
                        cand_w_reg   <= new_w_reg;
                        cand_a_reg   <= new_a_reg;
                        cand_b_reg   <= new_b_reg;
                        fx_reg       <= IDX_W'(new_a_reg);
                        which_reg    <= 1'b0;
                        state_reg    <= S_FIND_RD;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        cand_w_reg <= e_w;
                        cand_a_reg <= e_a;
                        cand_b_reg <= e_b;
                        fx_reg     <= IDX_W'(e_a);
                        which_reg  <= 1'b0;
                        state_reg  <= S_FIND_RD;
                    end
                end
                S_FIND_RD:
                begin
                    state_reg <= S_FIND_P;
                end
                S_FIND_P:
                begin
                    if (prdata == fx_reg)
                    begin
                        if (!which_reg)
                        begin
                            ra_reg    <= fx_reg;
                            fx_reg    <= IDX_W'(cand_b_reg);
                            which_reg <= 1'b1;
                            state_reg <= S_FIND_RD;
                        end
                        else
                        begin
                            state_reg <= S_UNION;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FIND_G;
                    end
                end
                S_FIND_G:
                begin
                    // Path halving: point x at its grandparent and advance
                    fx_reg    <= prdata;
                    state_reg <= S_FIND_P;
                end
                S_UNION:
                begin
                    if (ra_reg != fx_reg)
                    begin
                        kept_reg  <= kept_reg + 1'b1;
                        total_reg <= total_sat;
                    end
                    state_reg <= S_SCAN_RD;
                end
                S_DONE:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_data_reg.connected     <=
                            ((NODE_W + 1)'(kept_reg) + 1'b1) >= (NODE_W + 1)'(n_eff_reg);
                        result_data_reg.total_weight  <= total_reg;
                        result_data_reg.forest_size   <= kept_reg;
                        count_reg                     <= kept_reg;
                        bank_reg                      <= ~bank_reg;
                        state_reg                     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/imsf_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Used for the edge store and the union-find parent table. No dependencies.
module imsf_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
